// ===== src/rcppm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcppm_pkg
// Shared constants, types and helper functions of the PPM frame generator.
// ----------------------------------------------------------------------------
package rcppm_pkg;

   localparam int NUM_LINES     = 4;
   localparam int NUM_CHANNELS  = 9;
   localparam int FRACTION_BITS = 16;

   // Field widths of the streaming and register ports.
   localparam int CMD_W      = 2;
   localparam int LINE_IDX_W = 2;
   localparam int CH_IDX_W   = 4;
   localparam int RAW_W      = 19;
   localparam int LEVELS_W   = 4;
   localparam int TICK_W     = 12;
   localparam int FRAME_W    = 16;
   localparam int REM_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 1;

   localparam int FRAC_W    = FRACTION_BITS + 1;
   localparam int PROD_W    = TICK_W + FRAC_W;
   localparam int CH_CNT_W  = CH_IDX_W + 1;
   localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int WT_DEPTH  = NUM_LINES * NUM_CHANNELS;
   localparam int WT_ADDR_W = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;

   // A restore reloads this many leading channels of a line.
   localparam int RESTORE_CHANNELS = 6;
   localparam int HALF_FIRST_CH    = 1;
   localparam int HALF_LAST_CH     = 3;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRACTION_BITS;
   localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_ONE >> 1;

   // Commands carried in the request tuser.
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME    = 2'd3;

   localparam logic [TICK_W-1:0]  MARK_LEN_RESET = 12'd17;
   localparam logic [TICK_W-1:0]  MIN_GAP_RESET  = 12'd30;
   localparam logic [TICK_W-1:0]  SPAN_RESET     = 12'd44;
   localparam logic [FRAME_W-1:0] FRAME_RESET    = 16'd970;

   typedef enum logic [1:0] {
      PH_START,
      PH_GAP,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic [CH_IDX_W-1:0] ch;
      phase_type           phase;
      logic [REM_W-1:0]    rem;
   } line_state_type;

   typedef struct packed {
      logic                frame_start;
      logic [LEVELS_W-1:0] levels;
   } result_type;

   typedef struct packed {
      logic                  set_en;
      logic                  restore_en;
      logic [WT_ADDR_W-1:0]  addr;
      logic [LINE_IDX_W-1:0] line;
      logic [FRAC_W-1:0]     frac;
   } wt_write_type;

   typedef struct packed {
      logic                 en;
      logic [WT_ADDR_W-1:0] addr;
      logic [CH_IDX_W-1:0]  ch;
   } wt_read_type;

   function automatic logic [FRAC_W-1:0] default_fraction(input logic [CH_IDX_W-1:0] ch);
      return (ch >= CH_IDX_W'(HALF_FIRST_CH) && ch <= CH_IDX_W'(HALF_LAST_CH)) ?
             FRAC_HALF : '0;
   endfunction

   // Negative values clamp to zero, values above one clamp to one.
   function automatic logic [FRAC_W-1:0] clamp_fraction(input logic [RAW_W-1:0] raw);
      logic [FRAC_W-1:0] f;
      if (raw[RAW_W-1]) begin
         f = '0;
      end else if (raw > RAW_W'(FRAC_ONE)) begin
         f = FRAC_ONE;
      end else begin
         f = raw[FRAC_W-1:0];
      end
      return f;
   endfunction

   function automatic logic [WT_ADDR_W-1:0] wt_addr(input logic [WT_ADDR_W-1:0] line,
                                                    input logic [WT_ADDR_W-1:0] ch);
      return line * WT_ADDR_W'(NUM_CHANNELS) + ch;
   endfunction

   function automatic logic [REM_W-1:0] gap_ticks(input logic [TICK_W-1:0] span,
                                                  input logic [TICK_W-1:0] min_gap,
                                                  input logic [FRAC_W-1:0] frac);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(span) * PROD_W'(frac);
      return REM_W'(prod >> FRACTION_BITS) + REM_W'(min_gap);
   endfunction

   // A finished gap moves the line to the next channel's start pulse, or to
   // the tail after the last channel.
   function automatic line_state_type close_gap(input line_state_type s,
                                                input logic [TICK_W-1:0] mark_len);
      line_state_type      n;
      logic [CH_CNT_W-1:0] nxt;
      n   = s;
      nxt = {1'b0, s.ch} + CH_CNT_W'(1);
      if (s.phase == PH_GAP && s.rem == '0) begin
         n.ch = nxt[CH_IDX_W-1:0];
         if (nxt >= CH_CNT_W'(NUM_CHANNELS)) begin
            n.phase = PH_TAIL;
            n.rem   = '0;
         end else begin
            n.phase = PH_START;
            n.rem   = REM_W'(mark_len);
         end
      end
      return n;
   endfunction

   function automatic logic needs_width(input line_state_type s);
      return (s.phase == PH_START) && (s.rem == '0);
   endfunction

   function automatic line_state_type finish_tick(input line_state_type s);
      line_state_type n;
      n = s;
      if (s.phase != PH_TAIL && s.rem != '0) begin
         n.rem = s.rem - REM_W'(1);
      end
      return n;
   endfunction

endpackage

// ===== src/rc_ppm_frame_generator.sv =====
// ----------------------------------------------------------------------------
// rc_ppm_frame_generator
// Multi-line radio-control PPM frame generator with a width table in memory.
// ----------------------------------------------------------------------------
// A tick transaction yields one result through the output buffer; set and
// restore transactions yield none. Each time a line enters a channel gap, the
// tick waits in the fetch state for a read on the single read port of the
// width memory, once per gap entered in it (more when zero-length pulses or
// gaps are skipped), and no new request is taken meanwhile. The width table
// needs no clearing pass after reset.
module rc_ppm_frame_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] line_index, [5:2] channel_index, [24:6] width_fraction, zero pad
   input  logic [rcppm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [rcppm_pkg::REQ_USER_W-1:0]      req_tuser,  // [1:0] command
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rcppm_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [3:0] line_levels
   output logic [rcppm_pkg::RSP_USER_W-1:0]      rsp_tuser,  // [0] frame_start
   input  logic                                  csr_wr_en,
   input  logic [rcppm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcppm_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int NL = rcppm_pkg::NUM_LINES;
   localparam int LW = rcppm_pkg::LINE_W;

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } seq_state_type;

   // Request fields.
   logic [rcppm_pkg::CMD_W-1:0]      command;
   logic [rcppm_pkg::LINE_IDX_W-1:0] line_index;
   logic [rcppm_pkg::CH_IDX_W-1:0]   channel_index;
   logic [rcppm_pkg::RAW_W-1:0]      width_fraction;

   // Configuration.
   logic [rcppm_pkg::TICK_W-1:0]  mark_len_ff;
   logic [rcppm_pkg::TICK_W-1:0]  min_gap_ff;
   logic [rcppm_pkg::TICK_W-1:0]  span_ff;
   logic [rcppm_pkg::FRAME_W-1:0] frame_ticks_ff;

   // Sequencer and per-line state.
   seq_state_type              state_ff, state_in;
   rcppm_pkg::line_state_type  line_ff [NL];
   rcppm_pkg::line_state_type  line_in [NL];
   rcppm_pkg::line_state_type  stage [NL];
   rcppm_pkg::line_state_type  done [NL];
   rcppm_pkg::line_state_type  resolved;
   logic [NL-1:0]              need;
   logic [NL-1:0]              levels;
   logic                       any_need;
   logic [LW-1:0]              pick;
   logic [LW-1:0]              pend_line_ff, pend_line_in;
   logic                       first_ff, first_in;
   logic                       first_now;
   logic [rcppm_pkg::FRAME_W-1:0] pos_ff, pos_in, pos_next;

   logic accept, tick_accept, work, push, out_space;
   logic line_ok, ch_ok;
   logic [rcppm_pkg::FRAC_W-1:0] rd_fraction;
   rcppm_pkg::wt_write_type      wt_wr;
   rcppm_pkg::wt_read_type       wt_rd;
   rcppm_pkg::result_type        result;

   assign command        = req_tuser[rcppm_pkg::CMD_W-1:0];
   assign line_index     = req_tdata[1:0];
   assign channel_index  = req_tdata[5:2];
   assign width_fraction = req_tdata[24:6];

   assign req_tready  = (state_ff == S_IDLE) && out_space;
   assign accept      = req_tvalid && req_tready;
   assign tick_accept = accept && (command == rcppm_pkg::CMD_TICK);
   assign work        = tick_accept || (state_ff == S_FETCH);
   assign first_now   = (pos_ff == '0);

   assign line_ok = {1'b0, line_index} < (rcppm_pkg::LINE_IDX_W + 1)'(NL);
   assign ch_ok   = {1'b0, channel_index} < rcppm_pkg::CH_CNT_W'(rcppm_pkg::NUM_CHANNELS);

   always_comb begin
      wt_wr.set_en     = accept && (command == rcppm_pkg::CMD_SET) && line_ok && ch_ok;
      wt_wr.restore_en = accept && (command == rcppm_pkg::CMD_RESTORE) && line_ok;
      wt_wr.addr       = rcppm_pkg::wt_addr(rcppm_pkg::WT_ADDR_W'(line_index),
                                            rcppm_pkg::WT_ADDR_W'(channel_index));
      wt_wr.line       = line_index;
      wt_wr.frac       = rcppm_pkg::clamp_fraction(width_fraction);
   end

   // The fetched width closes the pending line's start pulse.
   always_comb begin
      resolved       = line_ff[pend_line_ff];
      resolved.phase = rcppm_pkg::PH_GAP;
      resolved.rem   = rcppm_pkg::gap_ticks(span_ff, min_gap_ff, rd_fraction);
      resolved       = rcppm_pkg::close_gap(resolved, mark_len_ff);
   end

   always_comb begin
      rcppm_pkg::line_state_type s;
      pick = '0;
      for (int l = NL - 1; l >= 0; l--) begin
         if (state_ff == S_FETCH) begin
            s = (pend_line_ff == LW'(l)) ? resolved : line_ff[l];
         end else begin
            s = line_ff[l];
            if (first_now) begin
               s.ch    = '0;
               s.phase = rcppm_pkg::PH_START;
               s.rem   = rcppm_pkg::REM_W'(mark_len_ff);
            end
            s = rcppm_pkg::close_gap(s, mark_len_ff);
         end
         stage[l]  = s;
         need[l]   = rcppm_pkg::needs_width(s);
         levels[l] = (s.phase == rcppm_pkg::PH_START);
         done[l]   = rcppm_pkg::finish_tick(s);
         if (need[l]) begin
            pick = LW'(l);
         end
      end
      any_need = |need;
   end

   always_comb begin
      wt_rd.en   = work && any_need;
      wt_rd.ch   = stage[pick].ch;
      wt_rd.addr = rcppm_pkg::wt_addr(rcppm_pkg::WT_ADDR_W'(pick),
                                      rcppm_pkg::WT_ADDR_W'(stage[pick].ch));
   end

   assign push               = work && !any_need;
   assign result.levels      = rcppm_pkg::LEVELS_W'(levels);
   assign result.frame_start = (state_ff == S_FETCH) ? first_ff : first_now;

   always_comb begin
      pos_next = pos_ff + rcppm_pkg::FRAME_W'(1);
      if (pos_next >= frame_ticks_ff) begin
         pos_next = '0;
      end
      pos_in       = tick_accept ? pos_next : pos_ff;
      first_in     = tick_accept ? first_now : first_ff;
      pend_line_in = (work && any_need) ? pick : pend_line_ff;
      state_in     = state_ff;
      for (int l = 0; l < NL; l++) begin
         line_in[l] = line_ff[l];
      end
      if (work) begin
         state_in = any_need ? S_FETCH : S_IDLE;
         for (int l = 0; l < NL; l++) begin
            line_in[l] = any_need ? stage[l] : done[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pos_ff         <= '0;
         first_ff       <= 1'b0;
         pend_line_ff   <= '0;
         mark_len_ff    <= rcppm_pkg::MARK_LEN_RESET;
         min_gap_ff     <= rcppm_pkg::MIN_GAP_RESET;
         span_ff        <= rcppm_pkg::SPAN_RESET;
         frame_ticks_ff <= rcppm_pkg::FRAME_RESET;
         for (int l = 0; l < NL; l++) begin
            line_ff[l].ch    <= '0;
            line_ff[l].phase <= rcppm_pkg::PH_START;
            line_ff[l].rem   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         pend_line_ff <= pend_line_in;
         for (int l = 0; l < NL; l++) begin
            line_ff[l] <= line_in[l];
         end
         if (csr_wr_en) begin
            case (csr_index)
               rcppm_pkg::CSR_MARK_LEN:
                  mark_len_ff <= csr_wr_data[rcppm_pkg::TICK_W-1:0];
               rcppm_pkg::CSR_MIN_GAP:
                  min_gap_ff <= csr_wr_data[rcppm_pkg::TICK_W-1:0];
               rcppm_pkg::CSR_SPAN:
                  span_ff <= csr_wr_data[rcppm_pkg::TICK_W-1:0];
               rcppm_pkg::CSR_FRAME:
                  frame_ticks_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   rcppm_width_store u_width_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (wt_wr),
      .rd          (wt_rd),
      .rd_fraction (rd_fraction)
   );

   rcppm_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (result),
      .space      (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_fetch_pending : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> rcppm_pkg::needs_width(line_ff[pend_line_ff]))
      else $error("fetching a width for a line that does not wait for one");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push |-> out_space)
      else $error("result produced without buffer room");

   a_fetch_from_tick : assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_FETCH) |-> $past(tick_accept))
      else $error("width fetch started without a tick transaction");

endmodule

// ===== src/rcppm_width_store.sv =====
// ----------------------------------------------------------------------------
// rcppm_width_store
// Channel width memory with one write and one registered read port. Per-entry
// valid bits make entries that were never written read as their reset value.
// ----------------------------------------------------------------------------
module rcppm_width_store (
   input  logic                                clock,
   input  logic                                reset,
   input  rcppm_pkg::wt_write_type             wr,
   input  rcppm_pkg::wt_read_type              rd,
   output logic [rcppm_pkg::FRAC_W-1:0]        rd_fraction
);

   logic [rcppm_pkg::FRAC_W-1:0]   mem [rcppm_pkg::WT_DEPTH];
   logic [rcppm_pkg::WT_DEPTH-1:0] valid_ff;
   logic [rcppm_pkg::FRAC_W-1:0]   rd_data_ff;
   logic                           rd_valid_ff;
   logic [rcppm_pkg::CH_IDX_W-1:0] rd_ch_ff;

   always_ff @(posedge clock) begin
      if (wr.set_en) begin
         mem[wr.addr] <= wr.frac;
      end
      if (rd.en) begin
         rd_data_ff  <= mem[rd.addr];
         rd_valid_ff <= valid_ff[rd.addr];
         rd_ch_ff    <= rd.ch;
      end
   end

   // A restore just drops the valid bits of the line's leading channels, whose
   // defaults equal their reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int e = 0; e < rcppm_pkg::WT_DEPTH; e++) begin
            if (wr.set_en && wr.addr == rcppm_pkg::WT_ADDR_W'(e)) begin
               valid_ff[e] <= 1'b1;
            end else if (wr.restore_en &&
                         wr.line == rcppm_pkg::LINE_IDX_W'(e / rcppm_pkg::NUM_CHANNELS) &&
                         (e % rcppm_pkg::NUM_CHANNELS) < rcppm_pkg::RESTORE_CHANNELS) begin
               valid_ff[e] <= 1'b0;
            end
         end
      end
   end

   assign rd_fraction = rd_valid_ff ? rd_data_ff : rcppm_pkg::default_fraction(rd_ch_ff);

   a_one_write_kind : assert property (@(posedge clock) disable iff (reset)
      !(wr.set_en && wr.restore_en))
      else $error("set and restore written in the same cycle");

endmodule

// ===== src/rcppm_out_buffer.sv =====
// ----------------------------------------------------------------------------
// rcppm_out_buffer
// Two-entry result buffer that drives the rsp stream and decouples it from
// the request side.
// ----------------------------------------------------------------------------
module rcppm_out_buffer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  rcppm_pkg::result_type                push_data,
   output logic                                 space,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rcppm_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [3:0] line_levels
   output logic [rcppm_pkg::RSP_USER_W-1:0]     rsp_tuser   // [0] frame_start
);

   rcppm_pkg::result_type head_ff;
   rcppm_pkg::result_type tail_ff;
   logic [1:0]            count_ff;
   logic                  pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign space      = (count_ff != 2'd2);
   assign rsp_tdata  = rcppm_pkg::RSP_DATA_W'(head_ff.levels);
   assign rsp_tuser  = head_ff.frame_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
      if (pop) begin
         head_ff <= (push && count_ff == 2'd1) ? push_data : tail_ff;
         if (push && count_ff == 2'd2) begin
            tail_ff <= push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_ff <= push_data;
         end else begin
            tail_ff <= push_data;
         end
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push && count_ff == 2'd2 |-> pop)
      else $error("result pushed into a full buffer");

endmodule

// ===== test/rc_ppm_frame_generator_tb.sv =====
// ----------------------------------------------------------------------------
// rc_ppm_frame_generator_tb
// Self-checking testbench for the multi-line PPM frame generator. A short
// table of directed transactions is followed by random tick, set and restore
// traffic under several register settings. Line samples are checked against a
// cycle-free software copy of the per-line pulse sequencer or directed values.
// ----------------------------------------------------------------------------
module rc_ppm_frame_generator_tb;

   localparam logic [rcppm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_CAP   = 40;

   typedef struct {
      logic [rcppm_pkg::CMD_W-1:0]      cmd;
      logic [rcppm_pkg::LINE_IDX_W-1:0] line;
      logic [rcppm_pkg::CH_IDX_W-1:0]   ch;
      logic [rcppm_pkg::RAW_W-1:0]      raw;
      bit                               typed;
      rcppm_pkg::result_type            want;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [rcppm_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic [rcppm_pkg::REQ_USER_W-1:0]   req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [rcppm_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [rcppm_pkg::RSP_USER_W-1:0]   rsp_tuser;
   logic                               csr_wr_en;
   logic [rcppm_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [rcppm_pkg::CSR_DATA_W-1:0]   csr_wr_data;

   // Copy of the generator state, advanced once per accepted transaction.
   logic [rcppm_pkg::TICK_W-1:0]       cfg_mark_len;
   logic [rcppm_pkg::TICK_W-1:0]       cfg_min_gap;
   logic [rcppm_pkg::TICK_W-1:0]       cfg_span;
   logic [rcppm_pkg::FRAME_W-1:0]      cfg_frame;
   logic [rcppm_pkg::FRAC_W-1:0]
      width_frac [rcppm_pkg::NUM_LINES][rcppm_pkg::NUM_CHANNELS];
   logic [rcppm_pkg::FRAME_W-1:0]      frame_pos;
   logic [rcppm_pkg::CH_IDX_W-1:0]     line_ch [rcppm_pkg::NUM_LINES];
   rcppm_pkg::phase_type               line_phase [rcppm_pkg::NUM_LINES];
   logic [rcppm_pkg::REM_W-1:0]        line_left [rcppm_pkg::NUM_LINES];

   rcppm_pkg::result_type              expected_samples [$];
   stim_row_type                       directed_rows [$];
   rcppm_pkg::result_type              head;

   bit                      steady;
   int                      stall_left;
   int                      quiet_cycles;
   int                      errors;
   int                      samples_checked;
   int                      set_count;
   int                      restore_count;
   int                      ignored_count;
   int                      settings_run;

   always #10 clock = ~clock;

   rc_ppm_frame_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Mostly no pause or a short one, now and then a long one.
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [rcppm_pkg::REM_W-1:0] gap_for(input int l, input int c);
      logic [rcppm_pkg::PROD_W-1:0] prod;
      prod = rcppm_pkg::PROD_W'(cfg_span) * rcppm_pkg::PROD_W'(width_frac[l][c]);
      return rcppm_pkg::REM_W'(prod >> rcppm_pkg::FRACTION_BITS) +
             rcppm_pkg::REM_W'(cfg_min_gap);
   endfunction

   // Walk past zero-length pulses and gaps, at most once around the channels.
   task automatic skip_empty(input int l);
      bit done;
      done = 1'b0;
      for (int g = 0; g < 2 * rcppm_pkg::NUM_CHANNELS + 2 && !done; g++) begin
         if (line_phase[l] == rcppm_pkg::PH_TAIL || line_left[l] != '0) begin
            done = 1'b1;
         end else if (line_phase[l] == rcppm_pkg::PH_START) begin
            line_phase[l] = rcppm_pkg::PH_GAP;
            line_left[l]  = gap_for(l, line_ch[l]);
         end else begin
            line_ch[l] = line_ch[l] + 1'b1;
            if (int'(line_ch[l]) >= rcppm_pkg::NUM_CHANNELS) begin
               line_phase[l] = rcppm_pkg::PH_TAIL;
               line_left[l]  = '0;
            end else begin
               line_phase[l] = rcppm_pkg::PH_START;
               line_left[l]  = rcppm_pkg::REM_W'(cfg_mark_len);
            end
         end
      end
   endtask

   task automatic advance_lines(output rcppm_pkg::result_type sample);
      logic                           first;
      logic [rcppm_pkg::LEVELS_W-1:0] lv;
      first = (frame_pos == '0);
      lv    = '0;
      for (int l = 0; l < rcppm_pkg::NUM_LINES; l++) begin
         if (first) begin
            line_ch[l]    = '0;
            line_phase[l] = rcppm_pkg::PH_START;
            line_left[l]  = rcppm_pkg::REM_W'(cfg_mark_len);
         end
         skip_empty(l);
         if (line_phase[l] == rcppm_pkg::PH_START) lv[l] = 1'b1;
         if (line_phase[l] != rcppm_pkg::PH_TAIL && line_left[l] != '0)
            line_left[l] = line_left[l] - 1'b1;
      end
      frame_pos = frame_pos + 1'b1;
      if (frame_pos >= cfg_frame) frame_pos = '0;
      sample.levels      = lv;
      sample.frame_start = first;
   endtask

   task automatic apply_request(input stim_row_type row);
      rcppm_pkg::result_type sample;
      case (row.cmd)
         rcppm_pkg::CMD_SET: begin
            set_count++;
            if (row.line < rcppm_pkg::NUM_LINES && row.ch < rcppm_pkg::NUM_CHANNELS) begin
               if (row.raw[rcppm_pkg::RAW_W-1])
                  width_frac[row.line][row.ch] = '0;
               else if (row.raw > rcppm_pkg::RAW_W'(rcppm_pkg::FRAC_ONE))
                  width_frac[row.line][row.ch] = rcppm_pkg::FRAC_ONE;
               else
                  width_frac[row.line][row.ch] = row.raw[rcppm_pkg::FRAC_W-1:0];
            end
         end
         rcppm_pkg::CMD_RESTORE: begin
            restore_count++;
            if (row.line < rcppm_pkg::NUM_LINES) begin
               for (int c = 0;
                    c < rcppm_pkg::RESTORE_CHANNELS && c < rcppm_pkg::NUM_CHANNELS; c++)
                  width_frac[row.line][c] =
                     (c >= rcppm_pkg::HALF_FIRST_CH && c <= rcppm_pkg::HALF_LAST_CH) ?
                     rcppm_pkg::FRAC_HALF : '0;
            end
         end
         rcppm_pkg::CMD_TICK: begin
            advance_lines(sample);
            expected_samples.push_back(row.typed ? row.want : sample);
         end
         default: ignored_count++;
      endcase
   endtask

   task automatic add_row(input logic [rcppm_pkg::CMD_W-1:0] cmd,
                          input logic [rcppm_pkg::LINE_IDX_W-1:0] line,
                          input logic [rcppm_pkg::CH_IDX_W-1:0] ch,
                          input logic [rcppm_pkg::RAW_W-1:0] raw,
                          input bit typed = 1'b0,
                          input logic [rcppm_pkg::LEVELS_W-1:0] lv = '0,
                          input logic fs = 1'b0);
      stim_row_type row;
      row.cmd   = cmd;
      row.line  = line;
      row.ch    = ch;
      row.raw   = raw;
      row.typed = typed;
      row.want.levels      = lv;
      row.want.frame_start = fs;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input stim_row_type row);
      int n;
      n = steady ? 0 : pause_len();
      @(negedge clock);
      if (n > 0) begin
         req_tvalid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = row.cmd;
      req_tdata  = {7'd0, row.raw, row.ch, row.line};
      do @(posedge clock); while (!req_tready);
      apply_request(row);
   endtask

   // Registers change only with nothing in flight and the block at rest.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rcppm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rcppm_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      case (idx)
         rcppm_pkg::CSR_MARK_LEN: cfg_mark_len = value[rcppm_pkg::TICK_W-1:0];
         rcppm_pkg::CSR_MIN_GAP:  cfg_min_gap  = value[rcppm_pkg::TICK_W-1:0];
         rcppm_pkg::CSR_SPAN:     cfg_span     = value[rcppm_pkg::TICK_W-1:0];
         rcppm_pkg::CSR_FRAME:    cfg_frame    = value[rcppm_pkg::FRAME_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= REPORT_CAP)
         $display("Mismatch at sample %0d, %s: got %0h, expected %0h",
                  samples_checked, what, got, want);
   endtask

   // Receiver side pacing.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready = 1'b0;
      end else begin
         stall_left = steady ? 0 : pause_len();
         rsp_tready = (stall_left == 0);
         if (stall_left > 0) stall_left = stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("sample with none expected", 32'({rsp_tuser, rsp_tdata}), '0);
         end else begin
            head = expected_samples.pop_front();
            samples_checked++;
            if (rsp_tdata[rcppm_pkg::LEVELS_W-1:0] !== head.levels)
               report_mismatch("line_levels", 32'(rsp_tdata[rcppm_pkg::LEVELS_W-1:0]),
                               32'(head.levels));
            if (rsp_tuser[0] !== head.frame_start)
               report_mismatch("frame_start", 32'(rsp_tuser[0]), 32'(head.frame_start));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      int           n;
      int           r;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = rcppm_pkg::CMD_TICK;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = rcppm_pkg::CSR_MARK_LEN;
      csr_wr_data = '0;
      steady      = 1'b0;
      stall_left  = 0;

      cfg_mark_len = rcppm_pkg::MARK_LEN_RESET;
      cfg_min_gap  = rcppm_pkg::MIN_GAP_RESET;
      cfg_span     = rcppm_pkg::SPAN_RESET;
      cfg_frame    = rcppm_pkg::FRAME_RESET;
      frame_pos    = '0;
      for (int l = 0; l < rcppm_pkg::NUM_LINES; l++) begin
         for (int c = 0; c < rcppm_pkg::NUM_CHANNELS; c++)
            width_frac[l][c] =
               (c >= rcppm_pkg::HALF_FIRST_CH && c <= rcppm_pkg::HALF_LAST_CH) ?
               rcppm_pkg::FRAC_HALF : '0;
         line_ch[l]    = '0;
         line_phase[l] = rcppm_pkg::PH_START;
         line_left[l]  = '0;
      end

      // Directed table, run at the reset settings. The first ticks fall in
      // the opening start pulse, so every line is high.
      add_row(rcppm_pkg::CMD_TICK,    2'd0, 4'd0,  19'h00000, 1'b1, 4'hF, 1'b1);
      add_row(rcppm_pkg::CMD_TICK,    2'd0, 4'd0,  19'h00000, 1'b1, 4'hF, 1'b0);
      add_row(rcppm_pkg::CMD_SET,     2'd0, 4'd0,
              rcppm_pkg::RAW_W'(rcppm_pkg::FRAC_ONE));
      add_row(rcppm_pkg::CMD_SET,     2'd1, 4'd0,  19'h7FFFF);  // minus one clamps to zero
      add_row(rcppm_pkg::CMD_SET,     2'd2, 4'd0,  19'h3FFFF);  // largest positive clamps to one
      add_row(rcppm_pkg::CMD_SET,     2'd3, 4'd0,  19'h40000);  // most negative
      add_row(rcppm_pkg::CMD_SET,     2'd0, 4'd8,  19'h10001);
      add_row(rcppm_pkg::CMD_SET,     2'd1, 4'd9,  19'h12345);  // channel past the end
      add_row(rcppm_pkg::CMD_SET,     2'd2, 4'd15, 19'h7FFFF);
      add_row(rcppm_pkg::CMD_SET,     2'd3, 4'd8,  19'h0FFFF);
      add_row(rcppm_pkg::CMD_RESTORE, 2'd2, 4'd0,  19'h00000);
      add_row(rcppm_pkg::CMD_RESTORE, 2'd3, 4'd15, 19'h7FFFF);
      add_row(CMD_UNUSED,             2'd3, 4'd15, 19'h7FFFF);
      add_row(CMD_UNUSED,             2'd0, 4'd0,  19'h00000);
      add_row(rcppm_pkg::CMD_TICK,    2'd0, 4'd0,  19'h00000, 1'b1, 4'hF, 1'b0);
      add_row(rcppm_pkg::CMD_TICK,    2'd3, 4'd15, 19'h7FFFF, 1'b1, 4'hF, 1'b0);
      add_row(rcppm_pkg::CMD_SET,     2'd0, 4'd1,  19'h00000);
      add_row(rcppm_pkg::CMD_TICK,    2'd1, 4'd2,  19'h2AAAA);
      add_row(rcppm_pkg::CMD_TICK,    2'd2, 4'd5,  19'h15555);
      add_row(rcppm_pkg::CMD_TICK,    2'd0, 4'd0,  19'h00000);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         case (p)
            0: begin
               write_reg(rcppm_pkg::CSR_MARK_LEN, 16'd3);
               write_reg(rcppm_pkg::CSR_MIN_GAP, 16'd2);
               write_reg(rcppm_pkg::CSR_SPAN, 16'd8);
               write_reg(rcppm_pkg::CSR_FRAME, 16'd60);
               n = 60;
            end
            1: begin  // a zero frame length restarts the frame on every tick
               write_reg(rcppm_pkg::CSR_MARK_LEN, 16'd1);
               write_reg(rcppm_pkg::CSR_MIN_GAP, 16'd0);
               write_reg(rcppm_pkg::CSR_SPAN, 16'd0);
               write_reg(rcppm_pkg::CSR_FRAME, 16'd0);
               n = 25;
            end
            2: begin  // every pulse and gap has zero length
               write_reg(rcppm_pkg::CSR_MARK_LEN, 16'd0);
               write_reg(rcppm_pkg::CSR_MIN_GAP, 16'd0);
               write_reg(rcppm_pkg::CSR_SPAN, 16'd0);
               write_reg(rcppm_pkg::CSR_FRAME, 16'd40);
               n = 40;
            end
            3: begin
               write_reg(rcppm_pkg::CSR_MARK_LEN, 16'd4095);
               write_reg(rcppm_pkg::CSR_MIN_GAP, 16'd4095);
               write_reg(rcppm_pkg::CSR_SPAN, 16'd4095);
               write_reg(rcppm_pkg::CSR_FRAME, 16'd65535);
               n = 25;
            end
            4: begin  // long gaps in a short frame, so frames are cut off
               write_reg(rcppm_pkg::CSR_MARK_LEN, 16'd2);
               write_reg(rcppm_pkg::CSR_MIN_GAP, 16'd1);
               write_reg(rcppm_pkg::CSR_SPAN, 16'd4095);
               write_reg(rcppm_pkg::CSR_FRAME, 16'd100);
               n = 60;
            end
            default: begin
               write_reg(rcppm_pkg::CSR_MARK_LEN,
                         rcppm_pkg::CSR_DATA_W'($urandom_range(0, 6)));
               write_reg(rcppm_pkg::CSR_MIN_GAP,
                         rcppm_pkg::CSR_DATA_W'($urandom_range(0, 10)));
               write_reg(rcppm_pkg::CSR_SPAN,
                         rcppm_pkg::CSR_DATA_W'($urandom_range(0, 80)));
               write_reg(rcppm_pkg::CSR_FRAME,
                         rcppm_pkg::CSR_DATA_W'($urandom_range(0, 150)));
               n = 55;
            end
         endcase
         settings_run++;
         steady = ($urandom_range(0, 3) == 0);

         for (int k = 0; k < n; k++) begin
            r         = $urandom_range(0, 99);
            row.line  = rcppm_pkg::LINE_IDX_W'($urandom_range(0, 3));
            row.ch    = rcppm_pkg::CH_IDX_W'($urandom_range(0, 15));
            row.raw   = rcppm_pkg::RAW_W'($urandom);
            row.typed = 1'b0;
            row.want  = '0;
            if (r < 70) begin
               row.cmd = rcppm_pkg::CMD_TICK;
            end else if (r < 88) begin
               row.cmd = rcppm_pkg::CMD_SET;
               if ($urandom_range(0, 6) != 0)
                  row.ch = rcppm_pkg::CH_IDX_W'($urandom_range(0, rcppm_pkg::NUM_CHANNELS - 1));
               case ($urandom_range(0, 5))
                  0:       row.raw = '0;
                  1:       row.raw = rcppm_pkg::RAW_W'(rcppm_pkg::FRAC_ONE);
                  2:       row.raw = rcppm_pkg::RAW_W'(rcppm_pkg::FRAC_HALF);
                  3, 4:    row.raw = rcppm_pkg::RAW_W'($urandom_range(0, rcppm_pkg::FRAC_ONE));
                  default: ;
               endcase
            end else if (r < 95) begin
               row.cmd = rcppm_pkg::CMD_RESTORE;
            end else begin
               row.cmd = CMD_UNUSED;
            end
            send_request(row);
         end
      end

      wait_idle();
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d line samples under %0d register settings after reset values.",
               samples_checked, settings_run);
      $display("Sent %0d width sets, %0d restores and %0d unused commands; %0d mismatches.",
               set_count, restore_count, ignored_count, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rcppm_pkg.sv
src/rcppm_width_store.sv
src/rcppm_out_buffer.sv
src/rc_ppm_frame_generator.sv
test/rc_ppm_frame_generator_tb.sv
